@@ src/jsu_pkg.sv @@
// shared types, codes and defaults for the json string unescaper
package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_ESCAPE = 3'd1;
    localparam logic [2:0] ERR_HEX    = 3'd2;
    localparam logic [2:0] ERR_CTRL   = 3'd3;
    localparam logic [2:0] ERR_UNTERM = 3'd4;

    // one decoded command from the front to the back
    typedef struct packed {
        logic        is_code;  // value holds a \u code to expand as utf-8
        logic [15:0] value;    // code, or the single byte in the low bits
        logic        valid;
        logic        done;
        logic [2:0]  err;
    } jsu_cmd_t;

endpackage

@@ src/jsu_front.sv @@
// front end: takes body bytes, tracks escapes and emits decode commands
module jsu_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // byte_value
    input  logic             s_tlast,   // text_end
    input  logic             queue_full,
    output logic             push,
    output jsu_pkg::jsu_cmd_t push_cmd
);
    import jsu_pkg::*;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_HEX   = 2'd2;

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] accum_reg, accum_next;
    logic        accept;
    logic [4:0]  hex_digit;  // bit 4 set when not a hex digit

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b0, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            r = {1'b0, b[3:0] + 4'd9};
        return r;
    endfunction

    assign s_tready  = !queue_full;
    assign accept    = s_tvalid && s_tready;
    assign hex_digit = hex_value(s_tdata);

    always_comb begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        accum_next   = accum_reg;
        push         = 1'b0;
        push_cmd     = '{is_code: 1'b0, value: 16'h0, valid: 1'b0, done: 1'b0,
                         err: ERR_NONE};
        if (accept) begin
            unique case (mode_reg)
                MODE_ESC: begin
                    mode_next = MODE_PLAIN;
                    push      = 1'b1;
                    push_cmd.valid = 1'b1;
                    if (s_tlast) begin
                        push_cmd.valid = 1'b0;
                        push_cmd.err   = ERR_ESCAPE;
                    end else begin
                        unique case (s_tdata) inside
                            8'h22, 8'h5C, 8'h2F: push_cmd.value = {8'h00, s_tdata};
                            8'h62: push_cmd.value = 16'h0008;
                            8'h66: push_cmd.value = 16'h000C;
                            8'h6E: push_cmd.value = 16'h000A;
                            8'h72: push_cmd.value = 16'h000D;
                            8'h74: push_cmd.value = 16'h0009;
                            8'h75: begin
                                mode_next    = MODE_HEX;
                                hex_cnt_next = 2'd0;
                                accum_next   = 16'h0;
                                push         = 1'b0;
                            end
                            default: begin
                                push_cmd.valid = 1'b0;
                                push_cmd.err   = ERR_ESCAPE;
                            end
                        endcase
                    end
                end
                MODE_HEX: begin
                    if (s_tlast || hex_digit[4]) begin
                        mode_next    = MODE_PLAIN;
                        hex_cnt_next = 2'd0;
                        accum_next   = 16'h0;
                        push         = 1'b1;
                        push_cmd.err = ERR_HEX;
                    end else if (hex_cnt_reg != 2'd3) begin
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                        accum_next   = {accum_reg[11:0], hex_digit[3:0]};
                    end else begin
                        mode_next        = MODE_PLAIN;
                        hex_cnt_next     = 2'd0;
                        accum_next       = 16'h0;
                        push             = 1'b1;
                        push_cmd.is_code = 1'b1;
                        push_cmd.valid   = 1'b1;
                        push_cmd.value   = {accum_reg[11:0], hex_digit[3:0]};
                    end
                end
                default: begin
                    mode_next = MODE_PLAIN;
                    push      = 1'b1;
                    if (s_tlast) begin
                        push_cmd.err = ERR_UNTERM;
                    end else if (s_tdata == 8'h22) begin
                        hex_cnt_next  = 2'd0;
                        accum_next    = 16'h0;
                        push_cmd.done = 1'b1;
                    end else if (s_tdata == 8'h5C) begin
                        mode_next = MODE_ESC;
                        push      = 1'b0;
                    end else if (s_tdata < 8'h20) begin
                        push_cmd.err = ERR_CTRL;
                    end else begin
                        push_cmd.valid = 1'b1;
                        push_cmd.value = {8'h00, s_tdata};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_PLAIN;
            hex_cnt_reg <= 2'd0;
            accum_reg   <= 16'h0;
        end else begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            accum_reg   <= accum_next;
        end
    end

endmodule

@@ src/jsu_queue.sv @@
// short command queue between the front and back ends
module jsu_queue #(
    parameter int Depth = jsu_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  jsu_pkg::jsu_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output jsu_pkg::jsu_cmd_t head,
    output logic              empty
);
    import jsu_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    jsu_cmd_t        slot_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign full  = (count_reg == FullCnt);
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ src/jsu_back.sv @@
// back end: expands commands into result transactions and holds the output register
module jsu_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  jsu_pkg::jsu_cmd_t head,
    input  logic              empty,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [4:0]        m_tuser,
    output logic              m_tlast
);
    import jsu_pkg::*;

    logic [1:0] phase_reg, phase_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic [4:0] m_tuser_reg;
    logic       m_tlast_reg;
    logic       load;
    logic [1:0] n_items;
    logic       last_item;
    logic [7:0] item_byte;

    assign load = !empty && (!m_tvalid_reg || m_tready);

    always_comb begin
        if (!head.is_code || head.value <= 16'h007F) n_items = 2'd1;
        else if (head.value <= 16'h07FF)             n_items = 2'd2;
        else                                         n_items = 2'd3;
    end

    assign last_item = (phase_reg == n_items - 2'd1);

    always_comb begin
        item_byte = head.value[7:0];
        if (head.is_code) begin
            case (n_items)
                2'd2: item_byte = (phase_reg == 2'd0) ? (8'hC0 | {3'b000, head.value[10:6]})
                                                      : (8'h80 | {2'b00, head.value[5:0]});
                2'd3: begin
                    case (phase_reg)
                        2'd0:    item_byte = 8'hE0 | {4'h0, head.value[15:12]};
                        2'd1:    item_byte = 8'h80 | {2'b00, head.value[11:6]};
                        default: item_byte = 8'h80 | {2'b00, head.value[5:0]};
                    endcase
                end
                default: item_byte = head.value[7:0];
            endcase
        end
    end

    assign pop           = load && last_item;
    assign phase_next    = load ? (last_item ? 2'd0 : phase_reg + 2'd1) : phase_reg;
    assign m_tvalid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= item_byte;
            m_tuser_reg <= {head.err, head.done, head.valid};
            m_tlast_reg <= last_item;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ src/json_string_unescape_utf8.sv @@
// top level of the json string unescaper with utf-8 output
//
//  channel | dir | tdata            | tuser                          | tlast
//  s_      | in  | byte_value       | -                              | text_end
//  m_      | out | out_byte         | out_valid, done_res, error_code | last
//
// one input transaction per cycle while the command queue has space
// a \u code drains as one to three output transactions, one per cycle while m_tready is high
// input reaches the output through the queue entry, then the output register
// aresetn clears the decode state, the queue pointers and count, and the output valid flag
// a stall on m_ fills the queue, then s_tready drops
module json_string_unescape_utf8 #(
    parameter int QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic       s_tlast,   // text_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [4:0] m_tuser,   // [0] out_valid, [1] done_res, [4:2] error_code
    output logic       m_tlast    // last
);
    import jsu_pkg::*;

    logic     queue_full, queue_empty, push, pop;
    jsu_cmd_t push_cmd, head;

    jsu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    jsu_queue #(.Depth(QueueDepth)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty)
    );

    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (queue_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/jsu_checker.sv @@
// port-level checks for the json string unescaper, bound to the top level
module jsu_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [4:0] m_tuser,
    input logic       m_tlast
);
    import jsu_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // a data byte carries no done and no error
    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1] && m_tuser[4:2] == ERR_NONE)
        else $error("data byte flagged as done or error");

    // done and error reports are single transactions with a zero byte
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
        else $error("status transaction not last or byte not zero");

    // error codes stay in the defined range, and done never comes with one
    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[4:2] <= ERR_UNTERM
                     && !(m_tuser[1] && m_tuser[4:2] != ERR_NONE))
        else $error("bad error code");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

@@ tb/tb_json_string_unescape_utf8.sv @@
// testbench for the json string unescaper: directed and random strings checked against a predictor
module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        MODE_BODY,
        MODE_ESCAPE,
        MODE_DIGITS
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       done;
        logic [2:0] err;
        logic       last;
    } out_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] byte_value
    logic       s_tlast = 1'b0;    // text_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] out_byte
    logic [4:0] m_tuser;           // [0] out_valid, [1] done_res, [4:2] error_code
    logic       m_tlast;           // last

    json_string_unescape_utf8 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    // predictor state
    scan_mode_t  scan_mode = MODE_BODY;
    logic [1:0]  digits_seen = 2'd0;
    logic [15:0] code_sum = 16'h0000;
    out_item_t   pending_out[$];

    int tx_gap_max = 12;
    int rx_gap_max = 12;
    int rx_wait = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int outputs_seen = 0;
    int strings_closed = 0;
    int error_reports = 0;
    int fail_count = 0;

    logic [7:0] short_escapes [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};

    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9") return 5'(b - "0");
        if (b >= "a" && b <= "f") return 5'(b - "a" + 10);
        if (b >= "A" && b <= "F") return 5'(b - "A" + 10);
        return 5'd16;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        if (nib < 4'd10) return 8'("0" + nib);
        return upper ? 8'("A" + nib - 10) : 8'("a" + nib - 10);
    endfunction

    function automatic out_item_t make_item(input logic [7:0] data, input logic valid,
                                            input logic done, input logic [2:0] err);
        out_item_t it;
        it.data = data;
        it.valid = valid;
        it.done = done;
        it.err = err;
        it.last = 1'b0;
        return it;
    endfunction

    task automatic clear_scan();
        scan_mode = MODE_BODY;
        digits_seen = 2'd0;
        code_sum = 16'h0000;
    endtask

    task automatic unescape_predict(input logic [7:0] b, input logic te);
        out_item_t   res [3];
        int          n;
        logic [4:0]  d;
        logic [15:0] c;
        n = 0;
        case (scan_mode)
            MODE_ESCAPE: begin
                if (te) begin
                    res[0] = make_item(8'h00, 1'b0, 1'b0, ERR_ESCAPE);
                    n = 1;
                    clear_scan();
                end else begin
                    n = 1;
                    scan_mode = MODE_BODY;
                    case (b)
                        CH_QUOTE, CH_BSLASH, "/": res[0] = make_item(b, 1'b1, 1'b0, ERR_NONE);
                        "b": res[0] = make_item(8'h08, 1'b1, 1'b0, ERR_NONE);
                        "f": res[0] = make_item(8'h0C, 1'b1, 1'b0, ERR_NONE);
                        "n": res[0] = make_item(8'h0A, 1'b1, 1'b0, ERR_NONE);
                        "r": res[0] = make_item(8'h0D, 1'b1, 1'b0, ERR_NONE);
                        "t": res[0] = make_item(8'h09, 1'b1, 1'b0, ERR_NONE);
                        CH_U: begin
                            n = 0;
                            scan_mode = MODE_DIGITS;
                            digits_seen = 2'd0;
                            code_sum = 16'h0000;
                        end
                        default: begin
                            res[0] = make_item(8'h00, 1'b0, 1'b0, ERR_ESCAPE);
                            clear_scan();
                        end
                    endcase
                end
            end
            MODE_DIGITS: begin
                d = hex_digit(b);
                if (te || d > 5'd15) begin
                    res[0] = make_item(8'h00, 1'b0, 1'b0, ERR_HEX);
                    n = 1;
                    clear_scan();
                end else begin
                    code_sum = {code_sum[11:0], d[3:0]};
                    if (digits_seen != 2'd3) begin
                        digits_seen = digits_seen + 2'd1;
                    end else begin
                        c = code_sum;
                        clear_scan();
                        if (c <= 16'h007F) begin
                            res[0] = make_item(c[7:0], 1'b1, 1'b0, ERR_NONE);
                            n = 1;
                        end else if (c <= 16'h07FF) begin
                            res[0] = make_item({3'b110, c[10:6]}, 1'b1, 1'b0, ERR_NONE);
                            res[1] = make_item({2'b10, c[5:0]}, 1'b1, 1'b0, ERR_NONE);
                            n = 2;
                        end else begin
                            res[0] = make_item({4'b1110, c[15:12]}, 1'b1, 1'b0, ERR_NONE);
                            res[1] = make_item({2'b10, c[11:6]}, 1'b1, 1'b0, ERR_NONE);
                            res[2] = make_item({2'b10, c[5:0]}, 1'b1, 1'b0, ERR_NONE);
                            n = 3;
                        end
                    end
                end
            end
            default: begin
                n = 1;
                if (te) begin
                    res[0] = make_item(8'h00, 1'b0, 1'b0, ERR_UNTERM);
                    clear_scan();
                end else if (b == CH_QUOTE) begin
                    res[0] = make_item(8'h00, 1'b0, 1'b1, ERR_NONE);
                    clear_scan();
                end else if (b == CH_BSLASH) begin
                    n = 0;
                    scan_mode = MODE_ESCAPE;
                end else if (b < CH_SPACE) begin
                    res[0] = make_item(8'h00, 1'b0, 1'b0, ERR_CTRL);
                    clear_scan();
                end else begin
                    res[0] = make_item(b, 1'b1, 1'b0, ERR_NONE);
                end
            end
        endcase
        for (int i = 0; i < n; i++) begin
            res[i].last = (i == n - 1);
            pending_out.insert(pending_out.size(), res[i]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic te);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= te ? 8'($urandom_range(0, 255)) : b;
        s_tlast <= te;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        unescape_predict(b, te);
        items_sent++;
    endtask

    task automatic send_unicode(input logic [15:0] code);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        for (int i = 3; i >= 0; i--) begin
            send_byte(hex_char(code[i*4 +: 4], 1'($urandom_range(0, 1))), 1'b0);
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endtask

    // receiver: random stall after each output transaction
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) rx_wait = $urandom_range(0, rx_gap_max);
        else if (!m_tready && rx_wait > 0) rx_wait--;
        m_tready <= (rx_wait == 0);
    end

    always @(posedge aclk) begin : check_out
        out_item_t got;
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tuser[0], m_tuser[1], m_tuser[4:2], m_tlast};
            outputs_seen++;
            if (got.done) strings_closed++;
            if (got.err != ERR_NONE) error_reports++;
            if (pending_out.size() == 0) begin
                note_failure($sformatf("output byte=%02h valid=%0b done=%0b err=%0d last=%0b%s",
                    got.data, got.valid, got.done, got.err, got.last, " with none expected"));
            end else begin
                want = pending_out.pop_front();
                if (got.data !== want.data || got.valid !== want.valid ||
                    got.done !== want.done || got.err !== want.err ||
                    got.last !== want.last) begin
                    note_failure($sformatf(
                        "expected byte=%02h valid=%0b done=%0b err=%0d last=%0b, %s%02h %s%0b %s%0b %s%0d %s%0b",
                        want.data, want.valid, want.done, want.err, want.last,
                        "got byte=", got.data, "valid=", got.valid, "done=", got.done,
                        "err=", got.err, "last=", got.last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d outputs still expected",
                     cycle_count, pending_out.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_plain_and_escapes();
        send_byte(CH_SPACE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte("z", 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic test_unicode_escapes();
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        send_byte("F", 1'b0);
        send_byte("f", 1'b0);
        send_byte("F", 1'b0);
        send_byte("f", 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        send_byte("0", 1'b0);
        send_byte("7", 1'b0);
        send_byte("g", 1'b0);
    endtask

    task automatic test_text_end();
        send_byte(CH_BSLASH, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_U, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic send_random_string();
        int          pieces;
        int          k;
        logic [7:0]  b;
        logic [15:0] code;
        pieces = $urandom_range(0, 8);
        for (int p = 0; p < pieces; p++) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                b = 8'($urandom_range(8'h20, 8'hFF));
                if (b == CH_QUOTE || b == CH_BSLASH) b = "a";
                send_byte(b, 1'b0);
            end else if (k < 65) begin
                send_byte(CH_BSLASH, 1'b0);
                send_byte(short_escapes[$urandom_range(0, 7)], 1'b0);
            end else if (k < 85) begin
                case ($urandom_range(0, 9))
                    0: code = 16'h0000;
                    1: code = 16'h007F;
                    2: code = 16'h0080;
                    3: code = 16'h07FF;
                    4: code = 16'h0800;
                    5: code = 16'hFFFF;
                    6: code = 16'($urandom_range(16'h0000, 16'h007F));
                    7: code = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: code = 16'($urandom_range(0, 16'hFFFF));
                endcase
                send_unicode(code);
            end else if (k < 92) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        send_byte(CH_BSLASH, 1'b0);
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                    end
                    1: begin
                        send_byte(CH_BSLASH, 1'b0);
                        send_byte(CH_U, 1'b0);
                        repeat ($urandom_range(0, 3)) send_byte(hex_char(4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1))), 1'b0);
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                    end
                    2: send_byte(8'h00, 1'b1);
                    default: send_byte(8'($urandom_range(0, 8'h1F)), 1'b0);
                endcase
            end
        end
        if ($urandom_range(0, 99) < 85) send_byte(CH_QUOTE, 1'b0);
        else send_byte(8'h00, 1'b1);
    endtask

    task automatic test_random_strings(input int count, input int tx_max, input int rx_max);
        int stop_at;
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        stop_at = items_sent + count;
        while (items_sent < stop_at) send_random_string();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_plain_and_escapes();
        test_unicode_escapes();
        test_text_end();
        test_random_strings(55, 12, 12);
        test_random_strings(50, 0, 0);
        test_random_strings(50, 12, 0);
        test_random_strings(50, 0, 12);
        s_tvalid <= 1'b0;
        wait (pending_out.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("sent %0d bytes and checked %0d output transactions", items_sent, outputs_seen);
        $display("%0d strings closed, %0d errors reported, %0d mismatches",
                 strings_closed, error_reports, fail_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ json_string_unescape_utf8.f @@
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8.sv
src/jsu_checker.sv
tb/tb_json_string_unescape_utf8.sv
